// ===== rtl/kcd_pkg.sv =====
// ----------------------------------------------------------------------------
// kcd_pkg
// shared types and constants of the key chord detector
// ----------------------------------------------------------------------------
package kcd_pkg;

    localparam int KEY_W       = 16;
    localparam int TIME_W      = 32;
    localparam int ACT_W       = 8;
    localparam int SETTLE_W    = 16;
    localparam int MAX_SLOTS   = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int POWER_BIT   = 6;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 16;
    localparam int OUTCOME_W   = 2;

    localparam logic [KEY_W-1:0] ELIGIBLE_RESET = 16'h007F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMBO_A   = 3'd0,
        REG_COMBO_B   = 3'd1,
        REG_COMBO_C   = 3'd2,
        REG_COMBO_D   = 3'd3,
        REG_ACTIONS   = 3'd4,
        REG_ELIGIBLE  = 3'd5,
        REG_SETTLE    = 3'd6
    } t_cfg_reg;

    localparam int CFG_COMBO_BASE = int'(REG_COMBO_A);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE     = 2'd0,
        OUT_CONSUMED = 2'd1,
        OUT_FIRED    = 2'd2
    } t_outcome;

    typedef struct packed {
        logic                  exact_hit;
        logic [SLOT_IDX_W-1:0] exact_slot;
        logic                  subset_hit;
    } t_match;

endpackage

// ===== rtl/kcd_match.sv =====
// ----------------------------------------------------------------------------
// kcd_match
// parallel compare of a key mask against the combo slots
// ----------------------------------------------------------------------------
module kcd_match #(
    parameter int SLOTS = kcd_pkg::MAX_SLOTS
) (
    input  logic [kcd_pkg::KEY_W-1:0] i_keys,
    input  logic [kcd_pkg::KEY_W-1:0] i_masks [SLOTS],
    output kcd_pkg::t_match           o_match
);

    always_comb begin
        o_match = '0;
        // walk downward so the lowest matching slot wins
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (i_keys != '0 && i_masks[s] == i_keys) begin
                o_match.exact_hit  = 1'b1;
                o_match.exact_slot = kcd_pkg::SLOT_IDX_W'(s);
            end
            if (i_masks[s] != '0 && (i_masks[s] & i_keys) == i_keys) begin
                o_match.subset_hit = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/key_chord_detector.sv =====
// ----------------------------------------------------------------------------
// key_chord_detector
// masks held keys, matches them against combo slots, fires a slot's action
// once the grip has settled and swallows frames until all keys are up
// ----------------------------------------------------------------------------
// channel  direction  handshake               beat contents
// s        in         i_s_tvalid/o_s_tready   pressed_keys, now_ms
// m        out        o_m_tvalid/i_m_tready   outcome, fired_action, held flags
// cfg      in         i_cfg_valid/o_cfg_ready register index, write data
//
// one frame per cycle sustained while m does not stall; a frame passes the input
// beat register, then slot compare and timer subtract into the result register
// reset is synchronous and clears the state and the register file defaults
// a stall on m holds the result register; the input register keeps accepting
// while the result register is free or being drained in the same cycle
// ----------------------------------------------------------------------------
module key_chord_detector #(
    parameter int SLOTS = kcd_pkg::MAX_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // [15:0] pressed_keys, [47:16] now_ms
    input  logic [kcd_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] outcome, [9:2] fired_action, [10] user_chord_held,
    // [11] power_chord_held, [15:12] zero
    output logic [kcd_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int KW = kcd_pkg::KEY_W;
    localparam int TW = kcd_pkg::TIME_W;
    localparam int AW = kcd_pkg::ACT_W;

    logic [KW-1:0]               r_combo_mask [SLOTS];
    logic [kcd_pkg::CFG_DATA_W-1:0] r_actions;
    logic [KW-1:0]               r_eligible;
    logic [kcd_pkg::SETTLE_W-1:0] r_settle;

    logic [KW-1:0]               r_prev_keys;
    logic [TW-1:0]               r_change_time;
    logic                        r_swallow;

    logic                        r_in_valid;
    logic [KW-1:0]               r_in_keys;
    logic [TW-1:0]               r_in_now;

    logic                        r_out_valid;
    kcd_pkg::t_outcome           r_outcome;
    logic [AW-1:0]               r_action;
    logic                        r_user_held;
    logic                        r_power_held;

    logic                        advance;
    logic [KW-1:0]               keys;
    logic                        multi;
    logic                        changed;
    logic [TW-1:0]               elapsed;
    logic [AW-1:0]               slot_act;
    kcd_pkg::t_match             match;

    kcd_pkg::t_outcome           n_outcome;
    logic [AW-1:0]               n_action;
    logic                        n_swallow;
    logic                        n_user_held;
    logic                        n_power_held;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign keys  = r_in_keys & r_eligible;
    assign multi = (keys & (keys - KW'(1))) != '0;

    kcd_match #(
        .SLOTS (SLOTS)
    ) u_match (
        .i_keys  (keys),
        .i_masks (r_combo_mask),
        .o_match (match)
    );

    assign changed  = keys != r_prev_keys;
    assign elapsed  = changed ? '0 : (r_in_now - r_change_time);
    assign slot_act = r_actions[AW*match.exact_slot +: AW];

    always_comb begin
        n_outcome    = kcd_pkg::OUT_NONE;
        n_action     = '0;
        n_swallow    = r_swallow;
        n_user_held  = multi && match.exact_hit;
        n_power_held = keys[kcd_pkg::POWER_BIT] && match.subset_hit;
        if (r_swallow) begin
            n_outcome = kcd_pkg::OUT_CONSUMED;
            if (keys == '0) begin
                n_swallow = 1'b0;
            end
        end else if (multi && match.subset_hit) begin
            if (elapsed < TW'(r_settle)) begin
                n_outcome = kcd_pkg::OUT_CONSUMED;
            end else if (match.exact_hit && slot_act != '0) begin
                n_outcome = kcd_pkg::OUT_FIRED;
                n_action  = slot_act;
                n_swallow = 1'b1;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_combo_mask[s] <= '0;
            end
            r_actions  <= '0;
            r_eligible <= kcd_pkg::ELIGIBLE_RESET;
            r_settle   <= '0;
        end else if (i_cfg_valid) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (i_cfg_index == kcd_pkg::CFG_IDX_W'(kcd_pkg::CFG_COMBO_BASE + s)) begin
                    r_combo_mask[s] <= i_cfg_data[KW-1:0];
                end
            end
            case (i_cfg_index)
                kcd_pkg::REG_ACTIONS:  r_actions  <= i_cfg_data;
                kcd_pkg::REG_ELIGIBLE: r_eligible <= i_cfg_data[KW-1:0];
                kcd_pkg::REG_SETTLE:   r_settle   <= i_cfg_data[kcd_pkg::SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state, updated as each frame moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys   <= '0;
            r_change_time <= '0;
            r_swallow     <= 1'b0;
        end else if (advance) begin
            r_swallow <= n_swallow;
            if (!r_swallow && changed) begin
                r_prev_keys   <= keys;
                r_change_time <= r_in_now;
            end
        end
    end

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_keys <= i_s_tdata[KW-1:0];
            r_in_now  <= i_s_tdata[KW +: TW];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_outcome    <= n_outcome;
            r_action     <= n_action;
            r_user_held  <= n_user_held;
            r_power_held <= n_power_held;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_power_held, r_user_held, r_action, r_outcome};

    a_fire_has_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_outcome == kcd_pkg::OUT_FIRED |-> r_action != '0)
        else $error("fired result without action code");

    a_action_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_outcome != kcd_pkg::OUT_FIRED |-> r_action == '0)
        else $error("action code on a result that did not fire");

    a_fire_starts_swallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_outcome == kcd_pkg::OUT_FIRED |=> r_swallow)
        else $error("swallowing not entered after fire");

    a_swallow_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_swallow |-> n_outcome == kcd_pkg::OUT_CONSUMED)
        else $error("frame not consumed while swallowing");

endmodule
